### rtl/core/prab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prab_pkg
// shared types and register map of the running-average background block
// ----------------------------------------------------------------------------
package prab_pkg;

  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 32;

  localparam int RATE_BITS = 16;
  localparam int ROWS_BITS = 10;
  localparam int COLS_BITS = 11;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_LEARNING_RATE = 2'd0,
    REG_FRAME_ROWS    = 2'd1,
    REG_FRAME_COLUMNS = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_index_t;

  localparam logic [RATE_BITS-1:0] LEARNING_RATE_RESET = 16'd3277;
  localparam logic [ROWS_BITS-1:0] FRAME_ROWS_RESET    = 10'd512;
  localparam logic [COLS_BITS-1:0] FRAME_COLUMNS_RESET = 11'd1024;

  typedef struct packed {
    logic [RATE_BITS-1:0] learning_rate;
    logic [ROWS_BITS-1:0] frame_rows;
    logic [COLS_BITS-1:0] frame_columns;
  } cfg_regs_t;

  // per-transaction flags from the raster scan
  typedef struct packed {
    logic first;  // copy mode, first frame after reset
    logic last;   // last pixel of the frame
  } scan_flags_t;

endpackage

### rtl/core/prab_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prab_cfg
// apb register file: learning rate and frame size
// ----------------------------------------------------------------------------
module prab_cfg
  import prab_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output cfg_regs_t                cfg
);

  reg_index_t reg_index;
  logic       wr_en;

  assign reg_index = reg_index_t'(paddr[3:2]);
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.learning_rate <= LEARNING_RATE_RESET;
      cfg.frame_rows    <= FRAME_ROWS_RESET;
      cfg.frame_columns <= FRAME_COLUMNS_RESET;
    end else if (wr_en) begin
      case (reg_index)
        REG_LEARNING_RATE: cfg.learning_rate <= pwdata[RATE_BITS-1:0];
        REG_FRAME_ROWS:    cfg.frame_rows    <= pwdata[ROWS_BITS-1:0];
        REG_FRAME_COLUMNS: cfg.frame_columns <= pwdata[COLS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_LEARNING_RATE: prdata = CFG_DATA_BITS'(cfg.learning_rate);
      REG_FRAME_ROWS:    prdata = CFG_DATA_BITS'(cfg.frame_rows);
      REG_FRAME_COLUMNS: prdata = CFG_DATA_BITS'(cfg.frame_columns);
      default:           prdata = '0;
    endcase
  end

endmodule

### rtl/core/prab_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prab_scan
// raster position counters and frame store address generation
// ----------------------------------------------------------------------------
module prab_scan
  import prab_pkg::*;
#(
  parameter int MAX_ROWS    = 512,
  parameter int MAX_COLUMNS = 1024,
  parameter int ADDR_BITS   = 19
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_regs_t            cfg,
  input  logic                 accept,
  output logic [ADDR_BITS-1:0] addr,
  output scan_flags_t          flags
);

  localparam int ROW_BITS = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_BITS = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  // compare widths hold both the register and the maximum
  localparam int ROW_CMP = ($clog2(MAX_ROWS + 1) > ROWS_BITS) ?
                           $clog2(MAX_ROWS + 1) + 1 : ROWS_BITS + 1;
  localparam int COL_CMP = ($clog2(MAX_COLUMNS + 1) > COLS_BITS) ?
                           $clog2(MAX_COLUMNS + 1) + 1 : COLS_BITS + 1;

  logic [ROW_BITS-1:0]  row_position;
  logic [COL_BITS-1:0]  column_position;
  logic [ADDR_BITS-1:0] row_base;
  logic                 first_frame;

  logic [ROW_CMP-1:0] rows_used;
  logic [COL_CMP-1:0] cols_used;
  logic [ROW_CMP-1:0] row_inc;
  logic [COL_CMP-1:0] col_inc;
  logic               row_wrap;
  logic               col_wrap;

  // zero means one, oversize saturates at the maximum
  always_comb begin
    if (cfg.frame_rows == '0) begin
      rows_used = ROW_CMP'(1);
    end else if (ROW_CMP'(cfg.frame_rows) > ROW_CMP'(MAX_ROWS)) begin
      rows_used = ROW_CMP'(MAX_ROWS);
    end else begin
      rows_used = ROW_CMP'(cfg.frame_rows);
    end
    if (cfg.frame_columns == '0) begin
      cols_used = COL_CMP'(1);
    end else if (COL_CMP'(cfg.frame_columns) > COL_CMP'(MAX_COLUMNS)) begin
      cols_used = COL_CMP'(MAX_COLUMNS);
    end else begin
      cols_used = COL_CMP'(cfg.frame_columns);
    end
  end

  assign col_inc  = COL_CMP'(column_position) + COL_CMP'(1);
  assign row_inc  = ROW_CMP'(row_position) + ROW_CMP'(1);
  assign col_wrap = (col_inc >= cols_used);
  assign row_wrap = (row_inc >= rows_used);

  assign addr        = row_base + ADDR_BITS'(column_position);
  assign flags.first = first_frame;
  assign flags.last  = col_wrap && row_wrap;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_position    <= '0;
      column_position <= '0;
      row_base        <= '0;
      first_frame     <= 1'b1;
    end else if (accept) begin
      if (!col_wrap) begin
        column_position <= col_inc[COL_BITS-1:0];
      end else begin
        column_position <= '0;
        if (!row_wrap) begin
          row_position <= row_inc[ROW_BITS-1:0];
          row_base     <= row_base + ADDR_BITS'(MAX_COLUMNS);
        end else begin
          row_position <= '0;
          row_base     <= '0;
          first_frame  <= 1'b0;
        end
      end
    end
  end

endmodule

### rtl/core/prab_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prab_update
// frame store, read-modify-write blend stage and output register
// ----------------------------------------------------------------------------
module prab_update
  import prab_pkg::*;
#(
  parameter int PIXEL_BITS  = 8,
  parameter int ADDR_BITS   = 19,
  parameter int STORE_DEPTH = 524288
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [RATE_BITS-1:0]  learning_rate,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIXEL_BITS-1:0] pixel_value,
  input  logic [ADDR_BITS-1:0]  addr,
  input  scan_flags_t           flags,
  output logic                  accept,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIXEL_BITS-1:0] background_value,
  output logic                  frame_end
);

  logic [PIXEL_BITS-1:0] store [STORE_DEPTH];
  logic [PIXEL_BITS-1:0] rdata;

  logic                  s1_valid;
  logic [PIXEL_BITS-1:0] s1_pixel;
  logic [ADDR_BITS-1:0]  s1_addr;
  scan_flags_t           s1_flags;
  logic                  s1_fwd;
  logic [PIXEL_BITS-1:0] s1_fwd_data;
  logic                  s1_adv;

  logic [PIXEL_BITS-1:0]        est;
  logic signed [PIXEL_BITS:0]   diff;
  logic signed [PIXEL_BITS+17:0] prod;
  logic [PIXEL_BITS+1:0]        sum;
  logic [PIXEL_BITS-1:0]        s1_result;

  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign accept   = in_valid && !in_stall;

  // one read and one write port; read data registered
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      store[s1_addr] <= s1_result;
    end
    if (accept) begin
      rdata <= store[addr];
    end
  end

  // the write of the previous pixel lands at the same edge as this read
  assign est  = s1_fwd ? s1_fwd_data : rdata;
  // est + floor(alpha * (pixel - est) / 2^16) equals the weighted sum
  assign diff = $signed({1'b0, s1_pixel}) - $signed({1'b0, est});
  assign prod = $signed({1'b0, learning_rate}) * diff;
  assign sum  = {2'b00, est} + prod[PIXEL_BITS+17:16];
  assign s1_result = s1_flags.first ? s1_pixel : sum[PIXEL_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel    <= pixel_value;
      s1_addr     <= addr;
      s1_flags    <= flags;
      s1_fwd      <= s1_adv && (s1_addr == addr);
      s1_fwd_data <= s1_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      background_value <= s1_result;
      frame_end        <= s1_flags.last;
    end
  end

endmodule

### rtl/core/pixel_running_average_background_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_running_average_background_top
// per-pixel running-average background estimator over a frame store
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one per clock unless in_stall is high, and
// each gives one estimate: the store read is registered with the pixel and
// the blend then goes to the output register and back to the store. A single
// read and a single write port set one pixel per cycle; a pixel that hits
// the entry still being written (a one-pixel frame) takes the new value by
// forwarding. The first frame after reset is copied into the store; later
// frames blend as est + alpha * (pixel - est) with alpha an unsigned Q0.16
// fraction, rounded down. The store holds MAX_ROWS * MAX_COLUMNS entries and
// is not cleared at reset, so enlarging the frame after the first frame
// reads entries that were never written.

module pixel_running_average_background_top
  import prab_pkg::*;
#(
  parameter int MAX_ROWS    = 512,
  parameter int MAX_COLUMNS = 1024,
  parameter int PIXEL_BITS  = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [PIXEL_BITS-1:0]    pixel_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [PIXEL_BITS-1:0]    background_value,
  output logic                     frame_end
);

  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int ADDR_BITS   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  cfg_regs_t            cfg;
  logic                 accept;
  logic [ADDR_BITS-1:0] addr;
  scan_flags_t          flags;

  prab_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  prab_scan #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .addr   (addr),
    .flags  (flags)
  );

  prab_update #(
    .PIXEL_BITS  (PIXEL_BITS),
    .ADDR_BITS   (ADDR_BITS),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_update (
    .clk              (clk),
    .rst              (rst),
    .learning_rate    (cfg.learning_rate),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .pixel_value      (pixel_value),
    .addr             (addr),
    .flags            (flags),
    .accept           (accept),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .background_value (background_value),
    .frame_end        (frame_end)
  );

`ifndef SYNTHESIS
  // input side only backs up when the output register is full and held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output side free");

  // copy mode ends with the last pixel of the first frame
  a_copy_ends: assert property (@(posedge clk) disable iff (rst)
    (accept && flags.last) |=> !flags.first)
    else $error("copy mode still set after frame end");

  // copy mode never comes back once left
  a_copy_once: assert property (@(posedge clk) disable iff (rst)
    !flags.first |=> !flags.first)
    else $error("copy mode re-entered");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule
